// ----- rtl/analog_angle_wrap_delta_core_assert.svh -----
// assertion macros for the angle sensor rtl
`ifndef ANALOG_ANGLE_WRAP_DELTA_CORE_ASSERT_SVH
`define ANALOG_ANGLE_WRAP_DELTA_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define AAWD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define AAWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/aawd_pkg.sv -----
// types and constants for the angle sensor core
`timescale 1ns / 1ps
`default_nettype none
package aawd_pkg;

  localparam int unsigned SMP_W     = 16;
  localparam int unsigned DIFF_W    = SMP_W + 1;
  localparam int unsigned PROD_W    = 26;
  localparam int unsigned NUM_W     = PROD_W - 1;
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam int unsigned TS_W      = 2;
  localparam int unsigned IDX_W     = 2;

  localparam logic signed [PROD_W-1:0] DEG_FULL_P = PROD_W'(360);
  localparam logic signed [SMP_W-1:0]  DEG_FULL   = SMP_W'(360);
  localparam logic signed [SMP_W-1:0]  DEG_HALF   = SMP_W'(180);
  localparam logic signed [SMP_W-1:0]  DEG_NHALF  = -SMP_W'(180);

  localparam logic [IDX_W-1:0] CFG_CAL_LOW   = 2'd0;
  localparam logic [IDX_W-1:0] CFG_CAL_HIGH  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_TURN_SIGN = 2'd2;

  localparam logic signed [SMP_W-1:0] CAL_LOW_RST   = 16'sd0;
  localparam logic signed [SMP_W-1:0] CAL_HIGH_RST  = 16'sd32767;
  localparam logic signed [TS_W-1:0]  TURN_SIGN_RST = 2'sd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_DIV,
    ST_FIX,
    ST_POST
  } aawd_state_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic load;
    logic step;
    logic fix;
    logic post;
  } aawd_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/aawd_ctrl.sv -----
// sequencer for the angle sensor core
`timescale 1ns / 1ps
`default_nettype none
`include "analog_angle_wrap_delta_core_assert.svh"
module aawd_ctrl
  import aawd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output aawd_cmd_t cmd
);

  aawd_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    in_stall      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        cnt_nxt   = CNT_W'(DIV_STEPS - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_FIX;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = ST_POST;
      end
      ST_POST: begin
        if (!out_valid_r || !out_stall) begin
          cmd.post      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  `AAWD_ASSERT_NEXT(a_accept_to_prep, clk, rst_n, in_valid && !in_stall, state_r == ST_PREP, "request accepted without starting work")
  `AAWD_ASSERT_NEXT(a_div_end, clk, rst_n, state_r == ST_DIV && cnt_r == '0, state_r == ST_FIX, "divider did not finish on count")
  `AAWD_ASSERT_IMPL(a_valid_from_post, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_POST, "result shown outside post step")
  `AAWD_ASSERT_IMPL(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd), "more than one datapath command")

endmodule
`default_nettype wire

// ----- rtl/aawd_dp.sv -----
// scaling, divider and shortest-path step datapath
`timescale 1ns / 1ps
`default_nettype none
module aawd_dp
  import aawd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire aawd_cmd_t               cmd,
  input  wire logic                    cfg_we,
  input  wire logic [IDX_W-1:0]        cfg_index,
  input  wire logic [SMP_W-1:0]        cfg_wdata,
  input  wire logic signed [SMP_W-1:0] in_adc_sample,
  output logic signed [SMP_W-1:0]      out_angle_deg,
  output logic signed [SMP_W-1:0]      out_angle_step,
  output logic                         out_moved,
  output logic                         out_cal_error
);

  logic signed [SMP_W-1:0]  cal_low_r;
  logic signed [SMP_W-1:0]  cal_high_r;
  logic signed [TS_W-1:0]   turn_sign_r;
  logic signed [SMP_W-1:0]  last_r;
  logic                     primed_r;

  logic signed [DIFF_W-1:0] diff_r;
  logic signed [DIFF_W-1:0] span_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [NUM_W-1:0]         quo_r;
  logic [SMP_W-1:0]         rem_r;
  logic [SMP_W-1:0]         dvs_r;
  logic                     neg_r;
  logic                     err_r;
  logic signed [SMP_W-1:0]  angle_r;

  logic signed [SMP_W-1:0]  angle_o_r;
  logic signed [SMP_W-1:0]  step_o_r;
  logic                     moved_o_r;
  logic                     err_o_r;

  logic signed [PROD_W-1:0] diff_ext;
  logic signed [PROD_W-1:0] prod_abs;
  logic signed [DIFF_W-1:0] span_abs;
  logic [SMP_W:0]           rem_sh;
  logic                     fits;
  logic [SMP_W:0]           rem_sub;
  logic [SMP_W-1:0]         quo_lo_neg;
  logic signed [SMP_W-1:0]  raw;
  logic signed [SMP_W-1:0]  raw_adj;
  logic signed [SMP_W+TS_W-1:0] step_full;
  logic signed [SMP_W-1:0]  step_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_low_r   <= CAL_LOW_RST;
      cal_high_r  <= CAL_HIGH_RST;
      turn_sign_r <= TURN_SIGN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAL_LOW:   cal_low_r   <= cfg_wdata;
        CFG_CAL_HIGH:  cal_high_r  <= cfg_wdata;
        CFG_TURN_SIGN: turn_sign_r <= cfg_wdata[TS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // multiply by full turn, then magnitudes for the divider
  assign diff_ext = PROD_W'(diff_r);
  assign prod_abs = prod_r[PROD_W-1] ? -prod_r : prod_r;
  assign span_abs = span_r[DIFF_W-1] ? -span_r : span_r;

  // restoring divide, one quotient bit a cycle
  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  assign quo_lo_neg = -quo_r[SMP_W-1:0];

  // shortest path step
  always_comb begin
    raw = angle_r - last_r;
    if (raw > DEG_HALF) begin
      raw_adj = raw - DEG_FULL;
    end else if (raw < DEG_NHALF) begin
      raw_adj = raw + DEG_FULL;
    end else begin
      raw_adj = raw;
    end
    step_full = (SMP_W+TS_W)'(raw_adj) * (SMP_W+TS_W)'(turn_sign_r);
    step_c    = primed_r ? step_full[SMP_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      diff_r <= DIFF_W'(in_adc_sample) - DIFF_W'(cal_low_r);
      span_r <= DIFF_W'(cal_high_r) - DIFF_W'(cal_low_r);
    end
    if (cmd.mul) begin
      prod_r <= diff_ext * DEG_FULL_P;
    end
    if (cmd.load) begin
      quo_r <= prod_abs[NUM_W-1:0];
      rem_r <= '0;
      dvs_r <= span_abs[SMP_W-1:0];
      neg_r <= prod_r[PROD_W-1] ^ span_r[DIFF_W-1];
      err_r <= (span_r == '0);
    end
    if (cmd.step) begin
      rem_r <= fits ? rem_sub[SMP_W-1:0] : rem_sh[SMP_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
    if (cmd.fix) begin
      if (err_r) begin
        angle_r <= '0;
      end else if (neg_r) begin
        angle_r <= quo_lo_neg;
      end else begin
        angle_r <= quo_r[SMP_W-1:0];
      end
    end
    if (cmd.post) begin
      angle_o_r <= angle_r;
      step_o_r  <= step_c;
      moved_o_r <= (step_c != '0);
      err_o_r   <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= '0;
      primed_r <= 1'b0;
    end else if (cmd.post) begin
      last_r   <= angle_r;
      primed_r <= 1'b1;
    end
  end

  assign out_angle_deg  = angle_o_r;
  assign out_angle_step = step_o_r;
  assign out_moved      = moved_o_r;
  assign out_cal_error  = err_o_r;

endmodule
`default_nettype wire

// ----- rtl/analog_angle_wrap_delta_core.sv -----
// Absolute angle sensor core: scales a converter sample to degrees and
// reports the shortest-path step from the previous angle.
// Input channel in_valid/in_stall carries one signed sample per request.
// Result channel out_valid/out_stall carries angle, step, moved and cal error.
// Config port: cfg_we with cfg_index 0 cal_low, 1 cal_high, 2 turn_sign;
// write only while no request is in flight.
// Sequence: capture, scale, load, then a 25-step restoring divider that
// divides the scaled sample by the calibration span, one bit per cycle,
// then sign fix and post to the output register. One request is in work
// at a time; the next is taken once the previous one has been posted.
// A finished result waits in the output register; a new request may be
// accepted meanwhile, and its result is held back until the old one is taken.
// Reset (rst_n low, synchronous) restores cal_low 0, cal_high 32767,
// turn_sign 1 and clears the previous angle; the first sample after reset
// gives step 0.
`timescale 1ns / 1ps
`default_nettype none
module analog_angle_wrap_delta_core
  import aawd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [SMP_W-1:0] in_adc_sample,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [SMP_W-1:0]      out_angle_deg,
  output logic signed [SMP_W-1:0]      out_angle_step,
  output logic                         out_moved,
  output logic                         out_cal_error,
  input  wire logic                    cfg_we,
  input  wire logic [IDX_W-1:0]        cfg_index,
  input  wire logic [SMP_W-1:0]        cfg_wdata
);

  aawd_cmd_t cmd;

  aawd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  aawd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_adc_sample  (in_adc_sample),
    .out_angle_deg  (out_angle_deg),
    .out_angle_step (out_angle_step),
    .out_moved      (out_moved),
    .out_cal_error  (out_cal_error)
  );

endmodule
`default_nettype wire

// ----- bench/tb_analog_angle_wrap_delta_core.sv -----
// self-checking bench for the angle sensor core: directed table, then randomized phases
`timescale 1ns / 1ps
module tb_analog_angle_wrap_delta_core;
  import aawd_pkg::*;

  localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 175;

  typedef struct packed {
    logic signed [SMP_W-1:0] angle;
    logic signed [SMP_W-1:0] step;
    logic                    moved;
    logic                    cal_err;
  } reading_t;

  typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [IDX_W-1:0] idx;
    logic [SMP_W-1:0] val;
    bit               typed;
    reading_t         res;
  } dir_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [SMP_W-1:0] in_adc_sample;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [SMP_W-1:0] out_angle_deg;
  logic signed [SMP_W-1:0] out_angle_step;
  logic                    out_moved;
  logic                    out_cal_error;
  logic                    cfg_we;
  logic [IDX_W-1:0]        cfg_index;
  logic [SMP_W-1:0]        cfg_wdata;

  // bench copy of the block's registers and history
  logic signed [SMP_W-1:0] cal_lo_m;
  logic signed [SMP_W-1:0] cal_hi_m;
  logic signed [TS_W-1:0]  turn_m;
  logic signed [SMP_W-1:0] prev_angle_m;
  bit                      primed_m;

  reading_t expected_readings[$];
  reading_t exp_r;
  int       fail_cnt;
  int       idle_cycles;
  int       gap_pct;
  int       stall_pct;

  dir_row_t dir_rows [0:28] = '{
    '{ROW_SAMPLE, '0, 16'h0000, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, '0, 16'h7FFF, 1'b1, '{16'sd360, 16'sd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, '0, 16'h8000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'h4000, 1'b0, '0},
    '{ROW_WRITE, CFG_CAL_HIGH, 16'h0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'h04D2, 1'b1, '{16'sd0, -16'sd180, 1'b1, 1'b1}},
    '{ROW_SAMPLE, '0, 16'h8000, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b1}},
    '{ROW_WRITE, CFG_CAL_LOW, 16'h8000, 1'b0, '0},
    '{ROW_WRITE, CFG_CAL_HIGH, 16'h7FFF, 1'b0, '0},
    '{ROW_WRITE, CFG_TURN_SIGN, 16'h0003, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'h7FFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'h0000, 1'b0, '0},
    '{ROW_WRITE, CFG_TURN_SIGN, 16'hFFFE, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'h8000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'h0064, 1'b0, '0},
    '{ROW_WRITE, CFG_TURN_SIGN, 16'h0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'h1388, 1'b0, '0},
    '{ROW_WRITE, CFG_UNUSED, 16'hFFFF, 1'b0, '0},
    '{ROW_WRITE, CFG_CAL_LOW, 16'h7FFF, 1'b0, '0},
    '{ROW_WRITE, CFG_CAL_HIGH, 16'h8000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'h8000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'h0000, 1'b0, '0},
    '{ROW_WRITE, CFG_CAL_LOW, 16'h0000, 1'b0, '0},
    '{ROW_WRITE, CFG_CAL_HIGH, 16'h0001, 1'b0, '0},
    '{ROW_WRITE, CFG_TURN_SIGN, 16'h0001, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'h7FFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'h8000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'h005B, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'hFFA5, 1'b0, '0}
  };

  analog_angle_wrap_delta_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_adc_sample  (in_adc_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_angle_deg  (out_angle_deg),
    .out_angle_step (out_angle_step),
    .out_moved      (out_moved),
    .out_cal_error  (out_cal_error),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic reading_t predict_reading(input logic signed [SMP_W-1:0] smp);
    longint                  span;
    longint                  quot;
    longint                  scaled_step;
    logic signed [SMP_W-1:0] ang;
    logic signed [SMP_W-1:0] diff;
    reading_t                r;
    span = longint'(cal_hi_m) - longint'(cal_lo_m);
    r.cal_err = (span == 0);
    ang = '0;
    if (span != 0) begin
      quot = ((longint'(smp) - longint'(cal_lo_m)) * 360) / span;
      ang = quot[SMP_W-1:0];
    end
    r.step = '0;
    if (primed_m) begin
      diff = ang - prev_angle_m;
      if (diff > 180) begin
        diff = diff - 16'sd360;
      end else if (diff < -180) begin
        diff = diff + 16'sd360;
      end
      scaled_step = longint'(diff) * longint'(turn_m);
      r.step = scaled_step[SMP_W-1:0];
    end
    r.angle = ang;
    r.moved = (r.step != 0);
    primed_m = 1'b1;
    prev_angle_m = ang;
    return r;
  endfunction

  function automatic logic signed [SMP_W-1:0] pick_sample(input logic signed [SMP_W-1:0] last);
    int lo_i;
    int hi_i;
    int w;
    int t;
    lo_i = (cal_lo_m < cal_hi_m) ? int'(cal_lo_m) : int'(cal_hi_m);
    hi_i = (cal_lo_m < cal_hi_m) ? int'(cal_hi_m) : int'(cal_lo_m);
    w = (hi_i - lo_i) / 8 + 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: t = int'(last) + int'($urandom_range(0, 2 * w)) - w;
      6, 7: t = lo_i + int'($urandom_range(0, hi_i - lo_i));
      8: t = int'($urandom);
      default: t = $urandom_range(0, 1) ? 32767 : -32768;
    endcase
    return t[SMP_W-1:0];
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SMP_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CAL_LOW: cal_lo_m = val;
      CFG_CAL_HIGH: cal_hi_m = val;
      CFG_TURN_SIGN: turn_m = val[TS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_sample(input logic signed [SMP_W-1:0] smp, input bit typed,
                             input reading_t typed_res);
    reading_t r;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_adc_sample <= smp;
    do @(posedge clk); while (in_stall);
    r = predict_reading(smp);
    expected_readings.push_back(typed ? typed_res : r);
  endtask

  // wait for every pending request to drain and the core to go idle
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        $error("result with no request pending");
        fail_cnt++;
      end else begin
        exp_r = expected_readings.pop_front();
        if (out_angle_deg !== exp_r.angle) begin
          $error("angle_deg: expected %0d, got %0d", exp_r.angle, out_angle_deg);
          fail_cnt++;
        end
        if (out_angle_step !== exp_r.step) begin
          $error("angle_step: expected %0d, got %0d", exp_r.step, out_angle_step);
          fail_cnt++;
        end
        if (out_moved !== exp_r.moved) begin
          $error("moved: expected %0d, got %0d", exp_r.moved, out_moved);
          fail_cnt++;
        end
        if (out_cal_error !== exp_r.cal_err) begin
          $error("cal_error: expected %0d, got %0d", exp_r.cal_err, out_cal_error);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic signed [SMP_W-1:0] smp;
    logic [SMP_W-1:0]        lo_v;
    logic [SMP_W-1:0]        hi_v;
    logic [SMP_W-1:0]        ts_v;
    int                      tmp;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_adc_sample <= '0;
    out_stall <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    cal_lo_m = CAL_LOW_RST;
    cal_hi_m = CAL_HIGH_RST;
    turn_m = TURN_SIGN_RST;
    prev_angle_m = '0;
    primed_m = 1'b0;
    fail_cnt = 0;
    idle_cycles = 0;
    gap_pct = 0;
    stall_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_sample(dir_rows[i].val, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 57; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 57; end
        default: begin gap_pct = 7; stall_pct = 7; end
      endcase
      ts_v = 16'($urandom);
      ts_v[TS_W-1:0] = TS_W'($urandom_range(0, 3));
      case (ph)
        0: begin lo_v = 16'h8000; hi_v = 16'h7FFF; ts_v[TS_W-1:0] = 2'b01; end
        1: begin
          tmp = -int'($urandom_range(0, 4000));
          lo_v = tmp[SMP_W-1:0];
          tmp = tmp + int'($urandom_range(1000, 30000));
          hi_v = tmp[SMP_W-1:0];
          ts_v[TS_W-1:0] = 2'b11;
        end
        2: begin lo_v = 16'($urandom); hi_v = 16'($urandom); end
        3: begin
          lo_v = 16'($urandom);
          hi_v = lo_v + 16'($urandom_range(1, 8));
        end
        4: begin
          tmp = -int'($urandom_range(0, 20000));
          hi_v = tmp[SMP_W-1:0];
          tmp = tmp + int'($urandom_range(500, 20000));
          lo_v = tmp[SMP_W-1:0];
          ts_v[TS_W-1:0] = 2'b10;
        end
        5: begin lo_v = 16'h0000; hi_v = 16'h7FFF; ts_v[TS_W-1:0] = 2'b00; end
        6: begin lo_v = 16'h7FFF; hi_v = 16'h8000; end
        default: begin lo_v = 16'($urandom); hi_v = lo_v; end
      endcase
      write_reg(CFG_CAL_LOW, lo_v);
      write_reg(CFG_CAL_HIGH, hi_v);
      write_reg(CFG_TURN_SIGN, ts_v);
      write_reg(CFG_UNUSED, 16'($urandom));
      smp = cal_lo_m;
      repeat (ITEMS_PER_PHASE) begin
        smp = pick_sample(smp);
        send_sample(smp, 1'b0, '0);
      end
    end

    settle();
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
